// ===== src/msbbp_pkg.sv =====
`default_nettype none

package msbbp_pkg;

    // Field widths of the input and result beats.
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 6;
    localparam int BYTE_BITS = 8;
    localparam int HELD_W    = 3;

    // Largest legal write width, in bits.
    localparam int MAX_WIDTH = 32;

    // Working window: up to seven held bits plus a full 32-bit write.
    localparam int WORD_W = VALUE_W + BYTE_BITS;

    // Bytes that one write can complete, plus room for zero.
    localparam int LEFT_W = 3;

    // What the back end has to do with a queued command.
    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_FLUSH,
        KIND_ERROR
    } t_kind;

    // One classified command as it sits in the queue.
    typedef struct packed {
        t_kind              kind;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
    } t_cmd;

    // Queue head as seen by the back end.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

    // Back-end sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

// ===== src/msbbp_front.sv =====
`default_nettype none

module msbbp_front #(
    parameter int DEPTH = 2
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire                          i_command,
    input  wire  [msbbp_pkg::VALUE_W-1:0] i_value,
    input  wire  [msbbp_pkg::COUNT_W-1:0] i_count,
    output msbbp_pkg::t_head             o_head,
    input  wire                          i_pop
);
    import msbbp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cmd             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_fill;
    t_cmd             n_cmd;
    logic             push;
    logic             pop;

    // Classify the incoming beat.
    always_comb begin
        n_cmd.value = i_value;
        n_cmd.count = i_count;
        if (i_command) begin
            n_cmd.kind = KIND_FLUSH;
        end else if (i_count == '0 || i_count > COUNT_W'(MAX_WIDTH)) begin
            n_cmd.kind = KIND_ERROR;
        end else begin
            n_cmd.kind = KIND_WRITE;
        end
    end

    assign o_ready = (r_fill != FULL_CNT);
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && (r_fill != '0);

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= n_cmd;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    assign o_head.valid = (r_fill != '0);
    assign o_head.cmd   = r_slot[r_rd_ptr];

endmodule

`default_nettype wire

// ===== src/msbbp_back.sv =====
`default_nettype none

module msbbp_back (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  msbbp_pkg::t_head         i_head,
    output logic                     o_pop,
    output logic                     o_valid,
    input  wire                      i_ready,
    output logic [7:0]               o_byte,
    output logic                     o_byte_valid,
    output logic                     o_error,
    output logic                     o_last
);
    import msbbp_pkg::*;

    // Packing state.
    t_state              r_state;
    t_state              n_state;
    logic [BYTE_BITS-1:0] r_partial;
    logic [BYTE_BITS-1:0] n_partial;
    logic [HELD_W-1:0]   r_held;
    logic [HELD_W-1:0]   n_held;

    // Window of bits still to be sent as bytes.
    logic [WORD_W-1:0]   r_word;
    logic [WORD_W-1:0]   n_word;
    logic [LEFT_W-1:0]   r_left;
    logic [LEFT_W-1:0]   n_left;
    logic [HELD_W-1:0]   r_rem;
    logic [HELD_W-1:0]   n_rem;

    // Output register.
    logic                r_out_valid;
    logic [BYTE_BITS-1:0] r_out_byte;
    logic                r_out_bv;
    logic                r_out_err;
    logic                r_out_last;
    logic                n_load;
    logic [BYTE_BITS-1:0] n_out_byte;
    logic                n_out_bv;
    logic                n_out_err;
    logic                n_out_last;

    // Write alignment: value bits left-justified, then placed behind the held bits.
    logic [VALUE_W-1:0]  aligned;
    logic [WORD_W-1:0]   merged;
    logic [COUNT_W-1:0]  total;
    logic                out_free;

    assign out_free = !r_out_valid || i_ready;
    assign aligned  = i_head.cmd.value << 5'(COUNT_W'(MAX_WIDTH) - i_head.cmd.count);
    assign merged   = {r_partial, {VALUE_W{1'b0}}} | ({aligned, {BYTE_BITS{1'b0}}} >> r_held);
    assign total    = i_head.cmd.count + COUNT_W'(r_held);

    // Sequencer: next state, state updates and result beats.
    always_comb begin
        n_state    = r_state;
        n_partial  = r_partial;
        n_held     = r_held;
        n_word     = r_word;
        n_left     = r_left;
        n_rem      = r_rem;
        n_load     = 1'b0;
        n_out_byte = '0;
        n_out_bv   = 1'b0;
        n_out_err  = 1'b0;
        n_out_last = 1'b1;
        o_pop      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid && out_free) begin
                    o_pop  = 1'b1;
                    n_load = 1'b1;
                    unique case (i_head.cmd.kind)
                        KIND_FLUSH: begin
                            if (r_held != '0) begin
                                n_out_byte = r_partial;
                                n_out_bv   = 1'b1;
                            end
                            n_partial = '0;
                            n_held    = '0;
                        end
                        KIND_ERROR: begin
                            n_out_err = 1'b1;
                        end
                        default: begin
                            if (total[COUNT_W-1:HELD_W] == '0) begin
                                // No byte completes: only the pending bits grow.
                                n_partial = merged[WORD_W-1 -: BYTE_BITS];
                                n_held    = total[HELD_W-1:0];
                            end else begin
                                n_load  = 1'b0;
                                n_word  = merged;
                                n_left  = total[COUNT_W-1:HELD_W];
                                n_rem   = total[HELD_W-1:0];
                                n_state = ST_EMIT;
                            end
                        end
                    endcase
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_load     = 1'b1;
                    n_out_byte = r_word[WORD_W-1 -: BYTE_BITS];
                    n_out_bv   = 1'b1;
                    n_out_last = (r_left == LEFT_W'(1));
                    n_word     = r_word << BYTE_BITS;
                    n_left     = r_left - 1'b1;
                    if (r_left == LEFT_W'(1)) begin
                        n_partial = r_word[WORD_W-BYTE_BITS-1 -: BYTE_BITS];
                        n_held    = r_rem;
                        n_state   = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_partial <= '0;
            r_held    <= '0;
        end else begin
            r_state   <= n_state;
            r_partial <= n_partial;
            r_held    <= n_held;
        end
    end

    // Byte window registers.
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_left <= n_left;
        r_rem  <= n_rem;
    end

    // Output beat register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_out_byte <= n_out_byte;
            r_out_bv   <= n_out_bv;
            r_out_err  <= n_out_err;
            r_out_last <= n_out_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_byte       = r_out_byte;
    assign o_byte_valid = r_out_bv;
    assign o_error      = r_out_err;
    assign o_last       = r_out_last;

endmodule

`default_nettype wire

// ===== src/msb_first_bit_packer_unit.sv =====
// Channel   Direction  Beat contents
// s_axis    in         tdata: value, bit_count; tuser: command
// m_axis    out        tdata: out_byte; tuser: byte_valid, error; tlast: last
//
// A flush, an error or a write that completes no byte is handled in the back end's
// idle state alone; a write completing bytes then runs the emit loop, one byte per
// cycle while the output is not stalled. The front queue keeps accepting beats while
// it has room, also while the back end works or the output is stalled. Reset is
// synchronous and clears the pending byte, the queue and the output valid flag.
`default_nettype none

module msb_first_bit_packer_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [39:0] i_s_axis_tdata,   // [31:0] value, [37:32] bit_count, rest zero
    input  wire         i_s_axis_tuser,   // [0] command
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]  o_m_axis_tuser,   // [0] byte_valid, [1] error
    output logic        o_m_axis_tlast
);
    import msbbp_pkg::*;

    t_head head;
    logic  pop;
    logic  byte_valid;
    logic  error;

    msbbp_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_command (i_s_axis_tuser),
        .i_value   (i_s_axis_tdata[VALUE_W-1:0]),
        .i_count   (i_s_axis_tdata[VALUE_W +: COUNT_W]),
        .o_head    (head),
        .i_pop     (pop)
    );

    msbbp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_byte       (o_m_axis_tdata),
        .o_byte_valid (byte_valid),
        .o_error      (error),
        .o_last       (o_m_axis_tlast)
    );

    assign o_m_axis_tuser = {error, byte_valid};

endmodule

`default_nettype wire
